// ===== rtl/core/ssa_pkg.sv =====
// Shared widths, defaults and status codes of the serial to slot allocator.
`default_nettype none
package ssa_pkg;

   localparam int SLOTS_DEFAULT = 64;
   localparam int SERIAL_W      = 32;
   localparam int SLOT_W        = 7;
   localparam int STATUS_W      = 2;

   localparam logic OP_ASSIGN = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_FOUND   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NEW     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_DELETED = 2'd3;

endpackage
`default_nettype wire

// ===== rtl/core/ssa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ssa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== rtl/core/serial_to_slot_allocator.sv =====
// Top level: slot table keyed by device serial, with lookup, allocate and delete.
//
//   channel | direction | ports
//   --------+-----------+-----------------------------------------------
//   req     | in        | req_valid/req_ready, req_op, req_serial, req_slot_index
//   rsp     | out       | rsp_valid/rsp_ready, rsp_slot, rsp_status, rsp_used_count
//
// A delete passes from idle to the finish step: req_ready returns once that step has
// moved its result into the rsp register. An assign reads the serial RAM one entry a cycle
// over all SLOTS entries; a hit on an existing serial stops the sweep early.
// Reset is synchronous and clears every valid bit and the used count at once.
// A result waiting in the rsp register holds only the finish step of the next item.
`default_nettype none
module serial_to_slot_allocator
   import ssa_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_op,
   input  wire logic [SERIAL_W-1:0] req_serial,
   input  wire logic [SLOT_W-1:0]   req_slot_index,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [SLOT_W-1:0]        rsp_slot,
   output logic [STATUS_W-1:0]      rsp_status,
   output logic [SLOT_W-1:0]        rsp_used_count
);

   localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int DW    = SLOT_W + CNT_W;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   function automatic logic [SLOT_W-1:0] slot_number(input logic [AW-1:0] k);
      logic [AW+SLOT_W:0] w;
      w = {{(SLOT_W+1){1'b0}}, k} + 1'b1;
      return w[SLOT_W-1:0];
   endfunction

   function automatic logic [SLOT_W-1:0] count_out(input logic [CNT_W-1:0] c);
      logic [CNT_W+SLOT_W-1:0] w;
      w = {{SLOT_W{1'b0}}, c};
      return w[SLOT_W-1:0];
   endfunction

   logic [1:0]          state_ff, state_in;
   logic [SERIAL_W-1:0] serial_ff, serial_in;
   logic [CNT_W-1:0]    issue_ff, issue_in;
   logic                chk_ff, chk_in;
   logic                chk_live_ff, chk_live_in;
   logic [AW-1:0]       chk_idx_ff, chk_idx_in;
   logic                free_found_ff, free_found_in;
   logic [AW-1:0]       free_idx_ff, free_idx_in;
   logic [SLOTS-1:0]    valid_ff, valid_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [SLOT_W-1:0]   res_slot_ff, res_slot_in;
   logic [STATUS_W-1:0] res_status_ff, res_status_in;
   logic [SLOT_W-1:0]   res_count_ff, res_count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [SLOT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic                ram_re, ram_we;
   logic [AW-1:0]       ram_raddr;
   logic [SERIAL_W-1:0] ram_rdata;

   logic [DW-1:0]       del_wide, del_m1;
   logic                del_in_range;
   logic [AW-1:0]       del_k;
   logic                hit;
   logic                req_xfer;
   logic                out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign del_wide     = {{CNT_W{1'b0}}, req_slot_index};
   assign del_m1       = del_wide - 1'b1;
   assign del_k        = del_m1[AW-1:0];
   assign del_in_range = (req_slot_index != '0) && (del_wide <= DW'(SLOTS));

   assign hit = chk_ff && chk_live_ff && (ram_rdata == serial_ff);

   always_comb begin
      state_in      = state_ff;
      serial_in     = serial_ff;
      issue_in      = issue_ff;
      chk_in        = chk_ff;
      chk_live_in   = chk_live_ff;
      chk_idx_in    = chk_idx_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      res_count_in  = res_count_ff;
      ram_re        = 1'b0;
      ram_raddr     = issue_ff[AW-1:0];
      ram_we        = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               if (req_op == OP_DELETE) begin
                  res_status_in = ST_DELETED;
                  if (del_in_range) begin
                     if (valid_ff[del_k] && (count_ff != '0)) begin
                        count_in = count_ff - 1'b1;
                     end
                     valid_in[del_k] = 1'b0;
                     res_slot_in     = req_slot_index;
                  end else begin
                     res_slot_in = '0;
                  end
                  res_count_in = count_out(count_in);
                  state_in     = S_FINISH;
               end else begin
                  serial_in     = req_serial;
                  issue_in      = '0;
                  chk_in        = 1'b0;
                  free_found_in = 1'b0;
                  state_in      = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (hit) begin
               res_slot_in   = slot_number(chk_idx_ff);
               res_status_in = ST_FOUND;
               res_count_in  = count_out(count_ff);
               chk_in        = 1'b0;
               state_in      = S_FINISH;
            end else begin
               // remember the lowest free entry seen so far
               if (chk_ff && !chk_live_ff && !free_found_ff) begin
                  free_found_in = 1'b1;
                  free_idx_in   = chk_idx_ff;
               end
               if (issue_ff != CNT_W'(SLOTS)) begin
                  ram_re      = 1'b1;
                  chk_in      = 1'b1;
                  chk_idx_in  = issue_ff[AW-1:0];
                  chk_live_in = valid_ff[issue_ff[AW-1:0]];
                  issue_in    = issue_ff + 1'b1;
               end else if (chk_ff) begin
                  chk_in = 1'b0;
               end else begin
                  // sweep done without a hit: allocate or report full
                  if (free_found_ff) begin
                     ram_we                = 1'b1;
                     valid_in[free_idx_ff] = 1'b1;
                     count_in              = count_ff + 1'b1;
                     res_slot_in           = slot_number(free_idx_ff);
                     res_status_in         = ST_NEW;
                  end else begin
                     res_slot_in   = '0;
                     res_status_in = ST_FULL;
                  end
                  res_count_in = count_out(count_in);
                  state_in     = S_FINISH;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_slot_in   = rsp_slot_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if ((state_ff == S_FINISH) && out_free) begin
         rsp_valid_in  = 1'b1;
         rsp_slot_in   = res_slot_ff;
         rsp_status_in = res_status_ff;
         rsp_count_in  = res_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         chk_ff        <= 1'b0;
         free_found_ff <= 1'b0;
         issue_ff      <= '0;
         valid_ff      <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         chk_ff        <= chk_in;
         free_found_ff <= free_found_in;
         issue_ff      <= issue_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      serial_ff     <= serial_in;
      chk_live_ff   <= chk_live_in;
      chk_idx_ff    <= chk_idx_in;
      free_idx_ff   <= free_idx_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      res_count_ff  <= res_count_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   ssa_ram #(
      .WIDTH(SERIAL_W),
      .DEPTH(SLOTS)
   ) u_serial_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(free_idx_ff),
      .wr_data(serial_ff),
      .rd_en  (ram_re),
      .rd_addr(ram_raddr),
      .rd_data(ram_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_used_count = rsp_count_ff;

endmodule
`default_nettype wire

// ===== rtl/core/ssa_checker.sv =====
// Port-level checks for the serial to slot allocator, bound to the top level.
`default_nettype none
module ssa_checker
   import ssa_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_ready,
   input wire logic                req_op,
   input wire logic [SERIAL_W-1:0] req_serial,
   input wire logic [SLOT_W-1:0]   req_slot_index,
   input wire logic                rsp_valid,
   input wire logic                rsp_ready,
   input wire logic [SLOT_W-1:0]   rsp_slot,
   input wire logic [STATUS_W-1:0] rsp_status,
   input wire logic [SLOT_W-1:0]   rsp_used_count
);

   // a waiting request holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_op) && $stable(req_serial)
         && $stable(req_slot_index))
      else $error("req changed while waiting");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_slot) && $stable(rsp_status)
         && $stable(rsp_used_count))
      else $error("rsp changed while stalled");

   a_full_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> (rsp_slot == '0))
      else $error("table full reported with a slot");

   a_new_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_NEW) |-> (rsp_slot != '0) && (rsp_used_count != '0))
      else $error("new slot without slot number or count");

   a_found_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FOUND) |-> (rsp_slot != '0) && (rsp_used_count != '0))
      else $error("found slot while table empty");

endmodule

bind serial_to_slot_allocator ssa_checker u_ssa_checker (.*);
`default_nettype wire

// ===== tb/serial_to_slot_allocator_tb.sv =====
// Testbench for the serial to slot allocator: directed corners, fill to full, random traffic.
`timescale 1ns / 1ps
module serial_to_slot_allocator_tb;
   import ssa_pkg::*;

   localparam int SLOTS = SLOTS_DEFAULT;
   localparam int MAX_SHOWN = 10;

   typedef struct packed {
      logic [SLOT_W-1:0]   slot;
      logic [STATUS_W-1:0] status;
      logic [SLOT_W-1:0]   used_count;
   } reply_type;

   typedef enum int {RDY_ALWAYS, RDY_COIN, RDY_SPARSE, RDY_BEAT} ready_mode_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_op = OP_ASSIGN;
   logic [SERIAL_W-1:0] req_serial = '0;
   logic [SLOT_W-1:0]   req_slot_index = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [SLOT_W-1:0]   rsp_slot;
   logic [STATUS_W-1:0] rsp_status;
   logic [SLOT_W-1:0]   rsp_used_count;

   // predicted table contents
   bit                  slot_used [SLOTS];
   logic [SERIAL_W-1:0] slot_serial [SLOTS];
   int                  used_slots = 0;

   reply_type pending_replies[$];
   int        errors = 0;

   // sender pacing
   int burst_left = 0;
   bit no_gaps = 1'b0;

   // receiver pacing
   ready_mode_type ready_mode = RDY_ALWAYS;
   int             mode_left = 0;
   logic [4:0]     beat_count = '0;

   serial_to_slot_allocator #(.SLOTS(SLOTS)) u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_serial     (req_serial),
      .req_slot_index (req_slot_index),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_slot       (rsp_slot),
      .rsp_status     (rsp_status),
      .rsp_used_count (rsp_used_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic reply_type apply_to_slot_table(logic op, logic [SERIAL_W-1:0] ser,
                                                     logic [SLOT_W-1:0] idx);
      reply_type r;
      int k;
      r.slot = '0;
      r.status = ST_FULL;
      if (op == OP_ASSIGN) begin
         for (k = 0; k < SLOTS; k++) begin
            if (slot_used[k] && slot_serial[k] == ser) begin
               r.slot = SLOT_W'(k + 1);
               r.status = ST_FOUND;
               r.used_count = SLOT_W'(used_slots);
               return r;
            end
         end
         for (k = 0; k < SLOTS; k++) begin
            if (!slot_used[k]) begin
               slot_used[k] = 1'b1;
               slot_serial[k] = ser;
               used_slots++;
               r.slot = SLOT_W'(k + 1);
               r.status = ST_NEW;
               r.used_count = SLOT_W'(used_slots);
               return r;
            end
         end
      end else begin
         r.status = ST_DELETED;
         // out-of-range index leaves the table alone
         if (idx != 0 && idx <= SLOTS) begin
            if (slot_used[idx - 1]) used_slots--;
            slot_used[idx - 1] = 1'b0;
            r.slot = idx;
         end
      end
      r.used_count = SLOT_W'(used_slots);
      return r;
   endfunction

   // random slot in use, 0 when the table is empty
   function automatic int pick_used_slot();
      int start;
      int k;
      start = $urandom_range(0, SLOTS - 1);
      for (k = 0; k < SLOTS; k++) begin
         if (slot_used[(start + k) % SLOTS]) return (start + k) % SLOTS + 1;
      end
      return 0;
   endfunction

   task automatic send_item(logic op, logic [SERIAL_W-1:0] ser, logic [SLOT_W-1:0] idx);
      int gap;
      req_valid <= 1'b1;
      req_op <= op;
      req_serial <= ser;
      req_slot_index <= idx;
      do @(posedge clock); while (!(req_valid && req_ready));
      pending_replies.push_back(apply_to_slot_table(op, ser, idx));
      if (burst_left > 0 || no_gaps) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 15);
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 90) : $urandom_range(0, 5);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_random_assign();
      int s;
      logic [SERIAL_W-1:0] ser;
      s = pick_used_slot();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: ser = (s != 0) ? slot_serial[s - 1] : $urandom;
         4:          ser = $urandom_range(0, 1) ? '0 : '1;
         default:    ser = $urandom;
      endcase
      send_item(OP_ASSIGN, ser, SLOT_W'($urandom));
   endtask

   task automatic send_random_delete();
      int s;
      int pick;
      pick = $urandom_range(0, 9);
      s = pick_used_slot();
      if (pick < 7 && s != 0) send_item(OP_DELETE, $urandom, SLOT_W'(s));
      else if (pick < 9) send_item(OP_DELETE, $urandom, SLOT_W'($urandom_range(1, SLOTS)));
      else send_item(OP_DELETE, $urandom, SLOT_W'($urandom_range(0, 127)));
   endtask

   task automatic test_assign_corners();
      send_item(OP_ASSIGN, 32'h0000_0000, 7'd0);
      send_item(OP_ASSIGN, 32'h0000_0000, 7'd127);
      send_item(OP_ASSIGN, 32'hFFFF_FFFF, 7'd127);
      send_item(OP_ASSIGN, 32'hA5A5_5A5A, 7'd1);
      send_item(OP_ASSIGN, 32'hFFFF_FFFF, 7'd64);
      send_item(OP_DELETE, 32'h0000_0000, 7'd1);
      send_item(OP_ASSIGN, 32'h5A5A_A5A5, 7'd0);
      send_item(OP_ASSIGN, 32'h0000_0000, 7'd0);
      send_item(OP_ASSIGN, 32'hA5A5_5A5A, 7'd85);
   endtask

   task automatic test_delete_corners();
      send_item(OP_DELETE, 32'hFFFF_FFFF, 7'd64);
      send_item(OP_DELETE, 32'h1234_5678, 7'd0);
      send_item(OP_DELETE, 32'h0000_0000, 7'd65);
      send_item(OP_DELETE, 32'hFFFF_FFFF, 7'd127);
      send_item(OP_DELETE, 32'hFFFF_FFFF, 7'd2);
      send_item(OP_DELETE, 32'h0000_0000, 7'd2);
      send_item(OP_DELETE, 32'h0000_0000, 7'd1);
      send_item(OP_DELETE, 32'h0000_0000, 7'd3);
      send_item(OP_DELETE, 32'h0000_0000, 7'd4);
   endtask

   task automatic test_fill_and_overflow();
      int s;
      while (used_slots < SLOTS) send_item(OP_ASSIGN, $urandom, SLOT_W'($urandom));
      send_item(OP_ASSIGN, $urandom, 7'd0);
      send_item(OP_ASSIGN, slot_serial[SLOTS - 1], 7'd0);
      send_item(OP_ASSIGN, slot_serial[0], 7'd0);
      send_item(OP_DELETE, $urandom, 7'd33);
      send_item(OP_DELETE, $urandom, SLOT_W'(SLOTS));
      send_item(OP_ASSIGN, $urandom, 7'd0);
      send_item(OP_ASSIGN, $urandom, 7'd0);
      send_item(OP_ASSIGN, $urandom, 7'd0);
      // drain back to empty
      for (s = 1; s <= SLOTS; s++) send_item(OP_DELETE, $urandom, SLOT_W'(s));
   endtask

   task automatic test_random_mix(int items);
      int done;
      int assign_pct;
      int phase_left;
      done = 0;
      phase_left = 0;
      assign_pct = 50;
      while (done < items) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(80, 200);
            case ($urandom_range(0, 2))
               0:       assign_pct = 90;
               1:       assign_pct = 60;
               default: assign_pct = 25;
            endcase
            no_gaps = ($urandom_range(0, 2) == 0);
         end
         if ($urandom_range(0, 99) < assign_pct) send_random_assign();
         else send_random_delete();
         phase_left--;
         done++;
      end
      no_gaps = 1'b0;
   endtask

   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode <= ready_mode_type'($urandom_range(0, 3));
         mode_left <= $urandom_range(20, 300);
      end else begin
         mode_left <= mode_left - 1;
      end
      beat_count <= beat_count + 1'b1;
      case (ready_mode)
         RDY_ALWAYS: rsp_ready <= 1'b1;
         RDY_COIN:   rsp_ready <= $urandom_range(0, 1);
         RDY_SPARSE: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:    rsp_ready <= beat_count[4];
      endcase
   end

   always @(posedge clock) begin
      reply_type expected;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_replies.size() == 0) begin
            errors++;
            if (errors <= MAX_SHOWN)
               $display("unexpected result: slot %0d status %0d used %0d",
                        rsp_slot, rsp_status, rsp_used_count);
         end else begin
            expected = pending_replies.pop_front();
            if (rsp_slot !== expected.slot || rsp_status !== expected.status ||
                rsp_used_count !== expected.used_count) begin
               errors++;
               if (errors <= MAX_SHOWN)
                  $display({"mismatch: expected slot %0d status %0d used %0d, ",
                            "got slot %0d status %0d used %0d"},
                           expected.slot, expected.status, expected.used_count,
                           rsp_slot, rsp_status, rsp_used_count);
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_assign_corners();
      test_delete_corners();
      test_fill_and_overflow();
      test_random_mix(1800);
      req_valid <= 1'b0;
      while (pending_replies.size() != 0) @(posedge clock);
      repeat (SLOTS + 8) @(posedge clock);
      errors += pending_replies.size();
      if (errors == 0) begin
         $display("** serial_to_slot_allocator: PASSED **");
      end else begin
         $display("** serial_to_slot_allocator: FAILED **");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("** serial_to_slot_allocator: FAILED **");
      $finish;
   end

endmodule
